[design/gpjd_pkg.sv]
// shared types and constants of the gnss position jump detector
// used by the controller, the datapath and the top level
package gpjd_pkg;

    localparam int RING_DEPTH_DEF     = 9;
    localparam int MIN_CONSISTENT_DEF = 7;

    localparam int COORD_W = 24;
    localparam int DIST_W  = 23;
    localparam int RES_W   = 25;
    localparam int SQ_W    = 50;
    localparam int ACC_W   = 51;
    localparam int TIME_W  = 48;
    localparam int COOL_W  = 32;
    localparam int FILL_W  = 4;
    localparam int TOTAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIST_W-1:0] MAX_ACC_RST = 23'd500;
    localparam logic [DIST_W-1:0] MARGIN_RST  = 23'd2000;
    localparam logic [DIST_W-1:0] WIDTH_RST   = 23'd20000;
    localparam logic [DIST_W-1:0] DEPTH_RST   = 23'd20000;
    localparam logic [DIST_W-1:0] SPREAD_RST  = 23'd300;
    localparam logic [DIST_W-1:0] MIN_RES_RST = 23'd1000;
    localparam logic [COOL_W-1:0] COOL_RST    = 32'd5000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ACC  = 3'd0,
        CFG_MARGIN   = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_DEPTH    = 3'd3,
        CFG_SPREAD   = 3'd4,
        CFG_MIN_RES  = 3'd5,
        CFG_COOLDOWN = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        SQ_NONE,
        SQ_SPREAD,
        SQ_MIN,
        SQ_RES_E,
        SQ_RES_N,
        SQ_MED_E,
        SQ_MED_N,
        SQ_DIFF_E,
        SQ_DIFF_N
    } sq_op_t;

    typedef struct packed {
        logic   latch_in;
        sq_op_t sq_op;
        logic   ring_update;
        logic   cons_clear;
        logic   load_cand;
        logic   med_cmp;
        logic   rotate;
        logic   med_eval;
        logic   cons_count;
        logic   decide;
        logic   out_load;
    } gpjd_cmd_t;

    typedef struct packed {
        logic check_go;
        logic med_big;
        logic cons_ok;
        logic out_free;
    } gpjd_status_t;

endpackage

[design/gpjd_ctrl.sv]
// sequencer of the jump detector: steps one item through squaring,
// ring update, serial median search and consistency count; uses gpjd_pkg
module gpjd_ctrl #(
    parameter int RING_DEPTH = gpjd_pkg::RING_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gpjd_pkg::gpjd_status_t status,
    output gpjd_pkg::gpjd_cmd_t   cmd
);

    localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int JW = $clog2(RING_DEPTH + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_SPR, S_SQ_MIN, S_SQ_RE, S_SQ_RN, S_UPD, S_CHECK, S_MED,
        S_MSQ_E, S_MSQ_N, S_MTEST, S_CSQ_E, S_CSQ_N, S_CCHK, S_DECIDE, S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [SW-1:0]   pass_reg, pass_next;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.sq_op  = gpjd_pkg::SQ_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_SQ_SPR;
                end
            end
            S_SQ_SPR:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_SPREAD;
                state_next = S_SQ_MIN;
            end
            S_SQ_MIN:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_MIN;
                state_next = S_SQ_RE;
            end
            S_SQ_RE:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_RES_E;
                state_next = S_SQ_RN;
            end
            S_SQ_RN:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_RES_N;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.ring_update = 1'b1;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.cons_clear = 1'b1;
                j_next         = '0;
                pass_next      = '0;
                state_next     = status.check_go ? S_MED : S_FINISH;
            end
            S_MED:
            begin
                if (j_reg == '0)
                begin
                    cmd.load_cand = 1'b1;
                    j_next        = j_reg + 1'b1;
                end
                else if (j_reg == JW'(RING_DEPTH + 1))
                begin
                    cmd.rotate   = 1'b1;
                    cmd.med_eval = 1'b1;
                    j_next       = '0;
                    if (pass_reg == SW'(RING_DEPTH - 1))
                        state_next = S_MSQ_E;
                    else
                        pass_next = pass_reg + 1'b1;
                end
                else
                begin
                    cmd.med_cmp = 1'b1;
                    cmd.rotate  = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
            end
            S_MSQ_E:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_MED_E;
                state_next = S_MSQ_N;
            end
            S_MSQ_N:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_MED_N;
                state_next = S_MTEST;
            end
            S_MTEST:
            begin
                pass_next  = '0;
                state_next = status.med_big ? S_CSQ_E : S_FINISH;
            end
            S_CSQ_E:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_DIFF_E;
                state_next = S_CSQ_N;
            end
            S_CSQ_N:
            begin
                cmd.sq_op  = gpjd_pkg::SQ_DIFF_N;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                cmd.cons_count = 1'b1;
                cmd.rotate     = 1'b1;
                if (pass_reg == SW'(RING_DEPTH - 1))
                    state_next = S_DECIDE;
                else
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = S_CSQ_E;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

[design/gpjd_datapath.sv]
// datapath of the jump detector: configuration registers, residual ring,
// shared squarer, median counters and result register; uses gpjd_pkg
module gpjd_datapath #(
    parameter int RING_DEPTH     = gpjd_pkg::RING_DEPTH_DEF,
    parameter int MIN_CONSISTENT = gpjd_pkg::MIN_CONSISTENT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gpjd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gpjd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   fix_valid,
    input  logic signed [gpjd_pkg::COORD_W-1:0]    fix_east_mm,
    input  logic signed [gpjd_pkg::COORD_W-1:0]    fix_north_mm,
    input  logic [gpjd_pkg::DIST_W-1:0]            fix_accuracy_mm,
    input  logic [gpjd_pkg::TIME_W-1:0]            fix_received_us,
    input  logic signed [gpjd_pkg::COORD_W-1:0]    est_east_mm,
    input  logic signed [gpjd_pkg::COORD_W-1:0]    est_north_mm,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   warp,
    output logic signed [gpjd_pkg::COORD_W-1:0]    warp_east_mm,
    output logic signed [gpjd_pkg::COORD_W-1:0]    warp_north_mm,
    output logic [gpjd_pkg::FILL_W-1:0]            ring_fill,
    output logic [gpjd_pkg::TOTAL_W-1:0]           warps_so_far,
    input  gpjd_pkg::gpjd_cmd_t                    cmd,
    output gpjd_pkg::gpjd_status_t                 status
);

    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int SW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int MID = RING_DEPTH / 2;
    localparam int CRW = gpjd_pkg::COORD_W;
    localparam int RW  = gpjd_pkg::RES_W;
    localparam int AW  = gpjd_pkg::ACC_W;
    localparam int DW  = gpjd_pkg::DIST_W;
    localparam int TW  = gpjd_pkg::TIME_W;

    // configuration
    logic [DW-1:0] max_acc_reg, margin_reg, width_reg, depth_reg, spread_reg, min_res_reg;
    logic [gpjd_pkg::COOL_W-1:0] cool_reg;

    // item
    logic                 usable_reg;
    logic signed [RW-1:0] re_reg, rn_reg;
    logic [TW-1:0]        now_reg;

    // ring and bookkeeping
    logic signed [CRW-1:0] ring_e_reg [RING_DEPTH];
    logic signed [CRW-1:0] ring_n_reg [RING_DEPTH];
    logic [SW-1:0]         slot_reg;
    logic [CW-1:0]         count_reg;
    logic [TW-1:0]         last_warp_reg;
    logic [gpjd_pkg::TOTAL_W-1:0] total_reg;

    // arithmetic
    logic [AW-1:0]         acc_reg, spread2_reg, min2_reg;
    logic signed [RW-1:0]  sq_in;
    logic signed [2*RW-1:0] sq_prod;
    logic [AW-1:0]         sq_ext;

    // median search
    logic signed [CRW-1:0] cand_e_reg, cand_n_reg, med_e_reg, med_n_reg;
    logic [CW-1:0]         less_e_reg, eq_e_reg, less_n_reg, eq_n_reg;
    logic [CW-1:0]         cons_reg;
    logic                  warp_reg;

    // result
    logic                  out_valid_reg;
    logic                  o_warp_reg;
    logic signed [CRW-1:0] o_east_reg, o_north_reg;
    logic [CW-1:0]         o_fill_reg;
    logic [gpjd_pkg::TOTAL_W-1:0] o_total_reg;

    logic signed [RW+1:0]  fe_x, fn_x, lo_x, hi_e_x, hi_n_x;
    logic                  usable_in;
    logic [TW-1:0]         elapsed;
    logic                  cool_block;
    logic [CW:0]           le_sum_e, le_sum_n;
    logic [CW+3:0]         fill_ext;
    logic [31:0]           cons_ext;

    function automatic logic signed [CRW-1:0] sat24(input logic signed [RW-1:0] v);
        if (v[RW-1] != v[RW-2])
            sat24 = v[RW-1] ? {1'b1, {(CRW-1){1'b0}}} : {1'b0, {(CRW-1){1'b1}}};
        else
            sat24 = v[CRW-1:0];
    endfunction

    // usable fix test on the incoming item
    always_comb
    begin
        fe_x   = {{3{fix_east_mm[CRW-1]}}, fix_east_mm};
        fn_x   = {{3{fix_north_mm[CRW-1]}}, fix_north_mm};
        lo_x   = -$signed({4'b0, margin_reg});
        hi_e_x = $signed({4'b0, width_reg}) + $signed({4'b0, margin_reg});
        hi_n_x = $signed({4'b0, depth_reg}) + $signed({4'b0, margin_reg});
        usable_in = fix_valid && (fix_accuracy_mm <= max_acc_reg)
                    && (fe_x >= lo_x) && (fn_x >= lo_x)
                    && (fe_x <= hi_e_x) && (fn_x <= hi_n_x);
    end

    // shared squarer
    always_comb
    begin
        unique case (cmd.sq_op)
            gpjd_pkg::SQ_SPREAD: sq_in = $signed({2'b0, spread_reg});
            gpjd_pkg::SQ_MIN:    sq_in = $signed({2'b0, min_res_reg});
            gpjd_pkg::SQ_RES_E:  sq_in = re_reg;
            gpjd_pkg::SQ_RES_N:  sq_in = rn_reg;
            gpjd_pkg::SQ_MED_E:  sq_in = {med_e_reg[CRW-1], med_e_reg};
            gpjd_pkg::SQ_MED_N:  sq_in = {med_n_reg[CRW-1], med_n_reg};
            gpjd_pkg::SQ_DIFF_E: sq_in = {ring_e_reg[0][CRW-1], ring_e_reg[0]}
                                         - {med_e_reg[CRW-1], med_e_reg};
            gpjd_pkg::SQ_DIFF_N: sq_in = {ring_n_reg[0][CRW-1], ring_n_reg[0]}
                                         - {med_n_reg[CRW-1], med_n_reg};
            default:             sq_in = '0;
        endcase
        sq_prod = sq_in * sq_in;
        sq_ext  = {1'b0, sq_prod[2*RW-1:0]};
    end

    assign elapsed    = now_reg - last_warp_reg;
    assign cool_block = (last_warp_reg != '0) && (now_reg >= last_warp_reg)
                        && (elapsed < {{(TW-gpjd_pkg::COOL_W){1'b0}}, cool_reg});
    assign le_sum_e   = {1'b0, less_e_reg} + {1'b0, eq_e_reg};
    assign le_sum_n   = {1'b0, less_n_reg} + {1'b0, eq_n_reg};
    assign cons_ext   = {{(32-CW){1'b0}}, cons_reg};

    assign status.check_go = (count_reg >= CW'(RING_DEPTH)) && !cool_block;
    assign status.med_big  = (acc_reg >= min2_reg);
    assign status.cons_ok  = (cons_ext >= 32'(MIN_CONSISTENT));
    assign status.out_free = !out_valid_reg || !out_stall;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_acc_reg <= gpjd_pkg::MAX_ACC_RST;
            margin_reg  <= gpjd_pkg::MARGIN_RST;
            width_reg   <= gpjd_pkg::WIDTH_RST;
            depth_reg   <= gpjd_pkg::DEPTH_RST;
            spread_reg  <= gpjd_pkg::SPREAD_RST;
            min_res_reg <= gpjd_pkg::MIN_RES_RST;
            cool_reg    <= gpjd_pkg::COOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gpjd_pkg::CFG_MAX_ACC:  max_acc_reg <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_MARGIN:   margin_reg  <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_WIDTH:    width_reg   <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_DEPTH:    depth_reg   <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_SPREAD:   spread_reg  <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_MIN_RES:  min_res_reg <= cfg_data[DW-1:0];
                gpjd_pkg::CFG_COOLDOWN: cool_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // item registers and arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            usable_reg <= usable_in;
            re_reg     <= {fix_east_mm[CRW-1], fix_east_mm} - {est_east_mm[CRW-1], est_east_mm};
            rn_reg     <= {fix_north_mm[CRW-1], fix_north_mm}
                          - {est_north_mm[CRW-1], est_north_mm};
            now_reg    <= fix_received_us;
        end
        unique case (cmd.sq_op)
            gpjd_pkg::SQ_SPREAD: spread2_reg <= sq_ext;
            gpjd_pkg::SQ_MIN:    min2_reg    <= sq_ext;
            gpjd_pkg::SQ_RES_E, gpjd_pkg::SQ_MED_E, gpjd_pkg::SQ_DIFF_E: acc_reg <= sq_ext;
            gpjd_pkg::SQ_RES_N, gpjd_pkg::SQ_MED_N, gpjd_pkg::SQ_DIFF_N:
                acc_reg <= acc_reg + sq_ext;
            default: ;
        endcase
        if (cmd.load_cand)
        begin
            cand_e_reg <= ring_e_reg[0];
            cand_n_reg <= ring_n_reg[0];
        end
        if (cmd.med_eval)
        begin
            if ((less_e_reg <= CW'(MID)) && ((CW+1)'(MID) < le_sum_e))
                med_e_reg <= cand_e_reg;
            if ((less_n_reg <= CW'(MID)) && ((CW+1)'(MID) < le_sum_n))
                med_n_reg <= cand_n_reg;
        end
    end

    // ring, rank counters and warp bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_e_reg[i] <= '0;
                ring_n_reg[i] <= '0;
            end
            slot_reg      <= '0;
            count_reg     <= '0;
            last_warp_reg <= '0;
            total_reg     <= '0;
            less_e_reg    <= '0;
            eq_e_reg      <= '0;
            less_n_reg    <= '0;
            eq_n_reg      <= '0;
            cons_reg      <= '0;
            warp_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
                warp_reg <= 1'b0;
            if (cmd.ring_update && usable_reg)
            begin
                if (acc_reg < spread2_reg)
                begin
                    slot_reg  <= '0;
                    count_reg <= '0;
                end
                else if (acc_reg >= min2_reg)
                begin
                    ring_e_reg[slot_reg] <= sat24(re_reg);
                    ring_n_reg[slot_reg] <= sat24(rn_reg);
                    slot_reg <= (slot_reg == SW'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    if (count_reg < CW'(RING_DEPTH))
                        count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.rotate)
            begin
                for (int i = 0; i < RING_DEPTH - 1; i++)
                begin
                    ring_e_reg[i] <= ring_e_reg[i+1];
                    ring_n_reg[i] <= ring_n_reg[i+1];
                end
                ring_e_reg[RING_DEPTH-1] <= ring_e_reg[0];
                ring_n_reg[RING_DEPTH-1] <= ring_n_reg[0];
            end
            if (cmd.load_cand)
            begin
                less_e_reg <= '0;
                eq_e_reg   <= '0;
                less_n_reg <= '0;
                eq_n_reg   <= '0;
            end
            if (cmd.med_cmp)
            begin
                if (ring_e_reg[0] < cand_e_reg)
                    less_e_reg <= less_e_reg + 1'b1;
                if (ring_e_reg[0] == cand_e_reg)
                    eq_e_reg <= eq_e_reg + 1'b1;
                if (ring_n_reg[0] < cand_n_reg)
                    less_n_reg <= less_n_reg + 1'b1;
                if (ring_n_reg[0] == cand_n_reg)
                    eq_n_reg <= eq_n_reg + 1'b1;
            end
            if (cmd.cons_clear)
                cons_reg <= '0;
            if (cmd.cons_count && (acc_reg <= spread2_reg))
                cons_reg <= cons_reg + 1'b1;
            if (cmd.decide && status.cons_ok)
            begin
                warp_reg      <= 1'b1;
                last_warp_reg <= now_reg;
                total_reg     <= total_reg + 1'b1;
                slot_reg      <= '0;
                count_reg     <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_warp_reg  <= warp_reg;
            o_east_reg  <= warp_reg ? med_e_reg : '0;
            o_north_reg <= warp_reg ? med_n_reg : '0;
            o_fill_reg  <= count_reg;
            o_total_reg <= total_reg;
        end
    end

    assign fill_ext      = {4'b0, o_fill_reg};
    assign out_valid     = out_valid_reg;
    assign warp          = o_warp_reg;
    assign warp_east_mm  = o_east_reg;
    assign warp_north_mm = o_north_reg;
    assign ring_fill     = fill_ext[gpjd_pkg::FILL_W-1:0];
    assign warps_so_far  = o_total_reg;

endmodule

[design/gnss_position_jump_detector_top.sv]
// top level of the gnss position jump detector
// joins gpjd_ctrl and gpjd_datapath; uses gpjd_pkg
//
// One fix enters when in_stall is low and leaves one result item. An item
// holds the controller through squaring and the ring update; when the ring
// check runs, also through the median search, and when the median offset is
// not too small, also through the consistency count. The median is found by
// rotating the ring past one comparator pair, one candidate after another.
// The consistency count shares the single squarer. A new item is taken as
// soon as the previous one is handed to the result register, which may still
// be waiting on out_stall.
module gnss_position_jump_detector_top #(
    parameter int RING_DEPTH     = gpjd_pkg::RING_DEPTH_DEF,
    parameter int MIN_CONSISTENT = gpjd_pkg::MIN_CONSISTENT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gpjd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpjd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                fix_valid,
    input  logic signed [gpjd_pkg::COORD_W-1:0] fix_east_mm,
    input  logic signed [gpjd_pkg::COORD_W-1:0] fix_north_mm,
    input  logic [gpjd_pkg::DIST_W-1:0]         fix_accuracy_mm,
    input  logic [gpjd_pkg::TIME_W-1:0]         fix_received_us,
    input  logic signed [gpjd_pkg::COORD_W-1:0] est_east_mm,
    input  logic signed [gpjd_pkg::COORD_W-1:0] est_north_mm,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                warp,
    output logic signed [gpjd_pkg::COORD_W-1:0] warp_east_mm,
    output logic signed [gpjd_pkg::COORD_W-1:0] warp_north_mm,
    output logic [gpjd_pkg::FILL_W-1:0]         ring_fill,
    output logic [gpjd_pkg::TOTAL_W-1:0]        warps_so_far
);

    gpjd_pkg::gpjd_cmd_t    cmd;
    gpjd_pkg::gpjd_status_t status;

    gpjd_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gpjd_datapath #(
        .RING_DEPTH     (RING_DEPTH),
        .MIN_CONSISTENT (MIN_CONSISTENT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fix_valid       (fix_valid),
        .fix_east_mm     (fix_east_mm),
        .fix_north_mm    (fix_north_mm),
        .fix_accuracy_mm (fix_accuracy_mm),
        .fix_received_us (fix_received_us),
        .est_east_mm     (est_east_mm),
        .est_north_mm    (est_north_mm),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .warp            (warp),
        .warp_east_mm    (warp_east_mm),
        .warp_north_mm   (warp_north_mm),
        .ring_fill       (ring_fill),
        .warps_so_far    (warps_so_far),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

[bench/tb_gnss_position_jump_detector_top.sv]
// self-checking testbench for gnss_position_jump_detector_top
// predicts every result item in-bench and compares it field by field
// depends on gpjd_pkg and the detector rtl only
`timescale 1ns / 100ps

module tb_gnss_position_jump_detector_top;

    localparam int DEPTH      = gpjd_pkg::RING_DEPTH_DEF;
    localparam int NEEDED     = gpjd_pkg::MIN_CONSISTENT_DEF;
    localparam int COORD_W    = gpjd_pkg::COORD_W;
    localparam int DIST_W     = gpjd_pkg::DIST_W;
    localparam int TIME_W     = gpjd_pkg::TIME_W;
    localparam int FILL_W     = gpjd_pkg::FILL_W;
    localparam int TOTAL_W    = gpjd_pkg::TOTAL_W;
    localparam int CFG_IDX_W  = gpjd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = gpjd_pkg::CFG_DATA_W;

    typedef struct {
        bit                        valid;
        logic signed [COORD_W-1:0] e;
        logic signed [COORD_W-1:0] n;
        logic [DIST_W-1:0]         acc;
        logic [TIME_W-1:0]         t;
        logic signed [COORD_W-1:0] ee;
        logic signed [COORD_W-1:0] en;
    } fix_t;

    typedef struct {
        bit                        warp;
        logic signed [COORD_W-1:0] we;
        logic signed [COORD_W-1:0] wn;
        logic [FILL_W-1:0]         fill;
        logic [TOTAL_W-1:0]        total;
    } jump_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic fix_valid;
    logic signed [COORD_W-1:0] fix_east_mm;
    logic signed [COORD_W-1:0] fix_north_mm;
    logic [DIST_W-1:0] fix_accuracy_mm;
    logic [TIME_W-1:0] fix_received_us;
    logic signed [COORD_W-1:0] est_east_mm;
    logic signed [COORD_W-1:0] est_north_mm;
    logic out_valid;
    logic out_stall;
    logic warp;
    logic signed [COORD_W-1:0] warp_east_mm;
    logic signed [COORD_W-1:0] warp_north_mm;
    logic [FILL_W-1:0] ring_fill;
    logic [TOTAL_W-1:0] warps_so_far;

    gnss_position_jump_detector_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .fix_valid(fix_valid), .fix_east_mm(fix_east_mm), .fix_north_mm(fix_north_mm),
        .fix_accuracy_mm(fix_accuracy_mm), .fix_received_us(fix_received_us),
        .est_east_mm(est_east_mm), .est_north_mm(est_north_mm),
        .out_valid(out_valid), .out_stall(out_stall),
        .warp(warp), .warp_east_mm(warp_east_mm), .warp_north_mm(warp_north_mm),
        .ring_fill(ring_fill), .warps_so_far(warps_so_far)
    );

    // predictor state
    longint max_acc, margin, width, depth, spread, min_res, cooldown;
    longint ring_e [DEPTH];
    longint ring_n [DEPTH];
    int unsigned write_slot, stored;
    longint unsigned last_warp_us;
    logic [TOTAL_W-1:0] warp_count;

    jump_result_t pending_results[$];
    int mismatches;
    bit idle_en;
    bit long_hold_pending;
    longint unsigned now_us;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint sat24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint median_value(longint src[DEPTH]);
        longint v[DEPTH];
        longint x;
        int p;
        v = src;
        for (int i = 1; i < DEPTH; i++)
        begin
            x = v[i];
            p = i;
            while (p > 0 && v[p-1] > x)
            begin
                v[p] = v[p-1];
                p--;
            end
            v[p] = x;
        end
        return v[DEPTH/2];
    endfunction

    function automatic jump_result_t predict_jump(fix_t f);
        jump_result_t r;
        longint fe, fn, re, rn, ce, cn, d2, spread2, min2;
        int unsigned s, consistent;
        fe = longint'(f.e);
        fn = longint'(f.n);
        spread2 = spread * spread;
        min2 = min_res * min_res;
        r.warp = 1'b0;
        r.we = '0;
        r.wn = '0;
        if (f.valid && longint'(f.acc) <= max_acc && fe >= -margin && fn >= -margin &&
            fe <= width + margin && fn <= depth + margin)
        begin
            re = fe - longint'(f.ee);
            rn = fn - longint'(f.en);
            d2 = re * re + rn * rn;
            if (d2 < spread2)
            begin
                stored = 0;
                write_slot = 0;
            end
            else if (d2 >= min2)
            begin
                s = (write_slot < DEPTH) ? write_slot : 0;
                ring_e[s] = sat24(re);
                ring_n[s] = sat24(rn);
                write_slot = (s + 1) % DEPTH;
                if (stored < DEPTH)
                    stored++;
            end
        end
        if (stored >= DEPTH && !(last_warp_us != 0 && longint'(f.t) >= last_warp_us &&
            longint'(f.t) - last_warp_us < cooldown))
        begin
            ce = median_value(ring_e);
            cn = median_value(ring_n);
            if (ce * ce + cn * cn >= min2)
            begin
                consistent = 0;
                for (int i = 0; i < DEPTH; i++)
                    if ((ring_e[i] - ce) * (ring_e[i] - ce) +
                        (ring_n[i] - cn) * (ring_n[i] - cn) <= spread2)
                        consistent++;
                if (consistent >= NEEDED)
                begin
                    r.warp = 1'b1;
                    r.we = ce[COORD_W-1:0];
                    r.wn = cn[COORD_W-1:0];
                    last_warp_us = f.t;
                    warp_count++;
                    stored = 0;
                    write_slot = 0;
                end
            end
        end
        r.fill = stored[FILL_W-1:0];
        r.total = warp_count;
        return r;
    endfunction

    task automatic send_fix(fix_t f);
        bit taken;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        fix_valid <= f.valid;
        fix_east_mm <= f.e;
        fix_north_mm <= f.n;
        fix_accuracy_mm <= f.acc;
        fix_received_us <= f.t;
        est_east_mm <= f.ee;
        est_north_mm <= f.en;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pending_results.push_back(predict_jump(f));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(gpjd_pkg::cfg_idx_t idx, longint unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            gpjd_pkg::CFG_MAX_ACC:  max_acc = value & 23'h7FFFFF;
            gpjd_pkg::CFG_MARGIN:   margin = value & 23'h7FFFFF;
            gpjd_pkg::CFG_WIDTH:    width = value & 23'h7FFFFF;
            gpjd_pkg::CFG_DEPTH:    depth = value & 23'h7FFFFF;
            gpjd_pkg::CFG_SPREAD:   spread = value & 23'h7FFFFF;
            gpjd_pkg::CFG_MIN_RES:  min_res = value & 23'h7FFFFF;
            gpjd_pkg::CFG_COOLDOWN: cooldown = value & 32'hFFFFFFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(longint unsigned a, longint unsigned m, longint unsigned w,
                             longint unsigned d, longint unsigned s, longint unsigned r,
                             longint unsigned c);
        write_reg(gpjd_pkg::CFG_MAX_ACC, a);
        write_reg(gpjd_pkg::CFG_MARGIN, m);
        write_reg(gpjd_pkg::CFG_WIDTH, w);
        write_reg(gpjd_pkg::CFG_DEPTH, d);
        write_reg(gpjd_pkg::CFG_SPREAD, s);
        write_reg(gpjd_pkg::CFG_MIN_RES, r);
        write_reg(gpjd_pkg::CFG_COOLDOWN, c);
        cfg_we <= 1'b0;
    endtask

    function automatic fix_t make_fix(bit v, longint e, longint n, longint a, longint t,
                                      longint ee, longint en);
        fix_t f;
        f.valid = v;
        f.e = COORD_W'(sat24(e));
        f.n = COORD_W'(sat24(n));
        f.acc = a[DIST_W-1:0];
        f.t = t[TIME_W-1:0];
        f.ee = COORD_W'(sat24(ee));
        f.en = COORD_W'(sat24(en));
        return f;
    endfunction

    function automatic longint next_time();
        case ($urandom_range(0, 39))
            0: now_us = {$urandom, $urandom} & 48'hFFFFFFFFFFFF;
            1: now_us = 0;
            2: now_us = now_us - $urandom_range(0, 10_000_000);
            default: now_us = now_us + $urandom_range(50_000, 3_000_000);
        endcase
        now_us &= 48'hFFFFFFFFFFFF;
        return now_us;
    endfunction

    function automatic fix_t noise_fix();
        fix_t f;
        f.valid = ($urandom_range(0, 1) != 0);
        f.e = COORD_W'($urandom);
        f.n = COORD_W'($urandom);
        f.acc = DIST_W'(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 600));
        f.t = TIME_W'(next_time());
        f.ee = COORD_W'($urandom);
        f.en = COORD_W'($urandom);
        return f;
    endfunction

    function automatic longint jump_axis();
        longint m;
        m = (min_res > 2_000_000) ? 2_000_000 : min_res;
        m = m + $urandom_range(0, 2 * m + 1);
        return ($urandom_range(0, 1) != 0) ? m : -m;
    endfunction

    // runs of fixes that jump by one common offset, mixed with noise fixes
    task automatic run_mix(int items);
        fix_t f;
        longint je, jn, jit, be, bn;
        int left, runlen;
        left = items;
        while (left > 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                je = jump_axis();
                jn = ($urandom_range(0, 3) == 0) ? 0 : jump_axis();
                jit = spread / 3;
                runlen = $urandom_range(9, 14);
                for (int i = 0; i < runlen && left > 0; i++)
                begin
                    be = $urandom_range(0, (width > 4_000_000) ? 4_000_000 : width);
                    bn = $urandom_range(0, (depth > 4_000_000) ? 4_000_000 : depth);
                    f = make_fix(1'b1, be + je + $urandom_range(0, 2 * jit) - jit,
                                 bn + jn + $urandom_range(0, 2 * jit) - jit,
                                 $urandom_range(0, (max_acc > 1000) ? 1000 : max_acc),
                                 next_time(), be, bn);
                    if ($urandom_range(0, 15) == 0)
                        f = noise_fix();
                    send_fix(f);
                    left--;
                end
            end
            else
            begin
                send_fix(noise_fix());
                left--;
            end
        end
    endtask

    task automatic test_field_and_accuracy_edges();
        wait_idle();
        send_fix(make_fix(1'b0, 8388607, 8388607, 8388607, 48'hFFFFFFFFFFFF, 8388607, 8388607));
        send_fix(make_fix(1'b1, 5000, 5000, 501, 1000, 0, 0));
        send_fix(make_fix(1'b1, -2000, -2000, 500, 2000, 0, 0));
        send_fix(make_fix(1'b1, 22000, 22000, 0, 3000, 20000, 20000));
        send_fix(make_fix(1'b1, -2001, 0, 0, 4000, 0, 0));
        send_fix(make_fix(1'b1, 0, 22001, 0, 5000, 0, 0));
        send_fix(make_fix(1'b1, 1000, 0, 0, 6000, 0, 0));
        send_fix(make_fix(1'b1, 500, 0, 0, 7000, 0, 0));
        send_fix(make_fix(1'b1, 300, 0, 0, 8000, 0, 0));
        send_fix(make_fix(1'b1, 100, 100, 0, 9000, 0, 0));
        // warp at time zero keeps the stamp at never
        for (int i = 0; i < DEPTH; i++)
            send_fix(make_fix(1'b1, 3000 + i, 1500, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            send_fix(make_fix(1'b1, -3000, -1500 - i, 0, 1, 0, 0));
    endtask

    task automatic test_register_extremes();
        fix_t f;
        wait_idle();
        write_all(8388607, 8388607, 8388607, 8388607, 8388607, 0, 32'hFFFFFFFF);
        f = make_fix(1'b1, 8388607, -8388608, 8388607, 48'hFFFFFFFFFFFF, -8388608, 8388607);
        send_fix(f);
        f = make_fix(1'b1, -8388608, 8388607, 0, 0, 8388607, -8388608);
        send_fix(f);
        run_mix(60);
        wait_idle();
        write_all(0, 0, 0, 0, 0, 0, 0);
        run_mix(60);
        wait_idle();
        write_all(8388607, 8388607, 8388607, 8388607, 2000, 8388607, 0);
        run_mix(60);
        wait_idle();
        write_all($urandom_range(200, 5000), $urandom_range(0, 100_000),
                  $urandom_range(1000, 1_000_000), $urandom_range(1000, 1_000_000),
                  $urandom_range(50, 2000), $urandom_range(100, 20_000), $urandom);
        run_mix(80);
    endtask

    task automatic test_jump_sequences();
        wait_idle();
        write_all(500, 2000, 20000, 20000, 300, 1000, 5000000);
        run_mix(250);
        wait_idle();
        write_all(2000, 50_000, 3_000_000, 3_000_000, 1500, 4000, 500_000);
        run_mix(200);
    endtask

    task automatic test_back_pressure();
        wait_idle();
        long_hold_pending = 1'b1;
        run_mix(60);
    endtask

    task automatic test_quiet_tail();
        wait_idle();
        idle_en = 1'b0;
        write_all(1000, 5000, 200_000, 200_000, 400, 1500, 1_000_000);
        run_mix(150);
    endtask

    // receiver side stalls
    initial begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    initial begin
        jump_result_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: warp %0d fill %0d", warp, ring_fill);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (warp !== exp_r.warp || warp_east_mm !== exp_r.we ||
                        warp_north_mm !== exp_r.wn || ring_fill !== exp_r.fill ||
                        warps_so_far !== exp_r.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                     exp_r.warp, exp_r.we, exp_r.wn, exp_r.fill, exp_r.total,
                                     warp, warp_east_mm, warp_north_mm, ring_fill,
                                     warps_so_far);
                    end
                end
            end
        end
    end

    initial begin
        int guard;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        fix_valid <= 1'b0;
        fix_east_mm <= '0;
        fix_north_mm <= '0;
        fix_accuracy_mm <= '0;
        fix_received_us <= '0;
        est_east_mm <= '0;
        est_north_mm <= '0;
        mismatches = 0;
        idle_en = 1'b1;
        long_hold_pending = 1'b0;
        now_us = 1000;
        max_acc = gpjd_pkg::MAX_ACC_RST;
        margin = gpjd_pkg::MARGIN_RST;
        width = gpjd_pkg::WIDTH_RST;
        depth = gpjd_pkg::DEPTH_RST;
        spread = gpjd_pkg::SPREAD_RST;
        min_res = gpjd_pkg::MIN_RES_RST;
        cooldown = gpjd_pkg::COOL_RST;
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_e[i] = 0;
            ring_n[i] = 0;
        end
        write_slot = 0;
        stored = 0;
        last_warp_us = 0;
        warp_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_and_accuracy_edges();
        test_register_extremes();
        test_jump_sequences();
        test_back_pressure();
        test_quiet_tail();

        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
